// ===== hdl/aalu_pkg.sv =====
`timescale 1ns / 1ps

package aalu_pkg;

  localparam int WordBits    = 16;
  localparam int OpBits      = 4;
  localparam int OperandBits = 16;
  localparam int ShiftBits   = 6;
  localparam int AccBits     = 16;

  typedef logic [WordBits-1:0]   word_t;
  typedef logic [ShiftBits-1:0]  shamt_t;

  typedef enum logic [OpBits-1:0] {
    OP_PASS   = 4'd0,
    OP_NAND   = 4'd1,
    OP_SHR1   = 4'd2,
    OP_ADD    = 4'd3,
    OP_NOT    = 4'd4,
    OP_AND    = 4'd5,
    OP_OR     = 4'd6,
    OP_XOR    = 4'd7,
    OP_LSHIFT = 4'd8,
    OP_NEGATE = 4'd9,
    OP_SUB    = 4'd10,
    OP_MUL    = 4'd11
  } op_e;

  typedef struct packed {
    logic z;
    logic c;
    logic o;
    logic n;
  } flags_t;

  typedef struct packed {
    word_t  acc;
    flags_t flags;
  } result_t;

endpackage

// ===== hdl/aalu_in_if.sv =====
`timescale 1ns / 1ps

interface aalu_in_if;
  logic                                valid;
  logic                                ready;
  logic [aalu_pkg::OpBits-1:0]         op;
  logic [aalu_pkg::OperandBits-1:0]    operand;
  logic signed [aalu_pkg::ShiftBits-1:0] shift_amount;

  modport source (output valid, output op, output operand, output shift_amount, input ready);
  modport sink (input valid, input op, input operand, input shift_amount, output ready);
endinterface

// ===== hdl/aalu_out_if.sv =====
`timescale 1ns / 1ps

interface aalu_out_if;
  logic                          valid;
  logic                          ready;
  logic [aalu_pkg::AccBits-1:0]  acc_value;
  logic                          zero_flag;
  logic                          carry_flag;
  logic                          overflow_flag;
  logic                          negative_flag;

  modport source (output valid, output acc_value, output zero_flag, output carry_flag,
                  output overflow_flag, output negative_flag, input ready);
  modport sink (input valid, input acc_value, input zero_flag, input carry_flag,
                input overflow_flag, input negative_flag, output ready);
endinterface

// ===== hdl/accumulator_alu_with_flags.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Payload
// in_i     sink       op, operand, shift_amount
// out_o    source     acc_value, zero_flag, carry_flag, overflow_flag, negative_flag
//
// One item is taken per cycle while in_i.ready is high; its result is registered.
// The accumulator and flags update at the edge that accepts an item.
// A two-entry output buffer (result register plus skid register) lets an item
// be accepted while a result waits; in_i.ready drops only when both are full.
// Reset clears the accumulator and the flags and empties both buffer entries.
module accumulator_alu_with_flags (
  input  logic clk_i,
  input  logic rst_ni,
  aalu_in_if.sink    in_i,
  aalu_out_if.source out_o
);

  aalu_pkg::word_t   acc_q;
  aalu_pkg::flags_t  flags_q;
  aalu_pkg::result_t res;
  aalu_pkg::result_t out_q, out_d;
  aalu_pkg::result_t skid_q, skid_d;
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  logic              accept;
  logic              take;

  aalu_core u_core (
    .acc_i          (acc_q),
    .flags_i        (flags_q),
    .op_i           (in_i.op),
    .operand_i      (in_i.operand),
    .shift_amount_i (in_i.shift_amount),
    .res_o          (res)
  );

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && !skid_valid_q;
  assign take       = out_valid_q && out_o.ready;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      flags_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        acc_q   <= res.acc;
        flags_q <= res.flags;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.acc_value     = aalu_pkg::AccBits'(out_q.acc);
  assign out_o.zero_flag     = out_q.flags.z;
  assign out_o.carry_flag    = out_q.flags.c;
  assign out_o.overflow_flag = out_q.flags.o;
  assign out_o.negative_flag = out_q.flags.n;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in front of it");

  a_acc_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(acc_q) && $stable(flags_q))
    else $error("accumulator changed without an accepted item");

  // The flags left by reset read Z clear on a zero accumulator, so only a set Z is checked.
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.flags.z || (out_q.acc == '0)))
    else $error("zero flag disagrees with the accumulator");

  a_neg_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.flags.n == out_q.acc[aalu_pkg::WordBits-1]))
    else $error("negative flag disagrees with the accumulator");

  a_result_tracks_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (!out_valid_q || take)) |=> (out_q == {acc_q, flags_q}))
    else $error("result register does not match the new accumulator");

endmodule

// ===== hdl/aalu_core.sv =====
`timescale 1ns / 1ps

// Computes the next accumulator and flags for one item.
module aalu_core (
  input  aalu_pkg::word_t                  acc_i,
  input  aalu_pkg::flags_t                 flags_i,
  input  logic [aalu_pkg::OpBits-1:0]      op_i,
  input  logic [aalu_pkg::OperandBits-1:0] operand_i,
  input  logic signed [aalu_pkg::ShiftBits-1:0] shift_amount_i,
  output aalu_pkg::result_t                res_o
);

  localparam int W = aalu_pkg::WordBits;

  aalu_pkg::word_t  b;
  logic [W:0]       sum;
  logic             add_ovf;
  aalu_pkg::shamt_t mag;
  aalu_pkg::shamt_t k;
  logic [W:0]       shl;
  logic [W:0]       shr;
  aalu_pkg::word_t  r;
  logic             c;
  logic             o;
  logic             keep;

  assign b       = aalu_pkg::word_t'(operand_i);
  assign sum     = {1'b0, acc_i} + {1'b0, b};
  assign add_ovf = (acc_i[W-1] == b[W-1]) && (sum[W-1] != acc_i[W-1]);

  assign mag = shift_amount_i[aalu_pkg::ShiftBits-1] ? aalu_pkg::shamt_t'(-shift_amount_i)
                                                     : aalu_pkg::shamt_t'(shift_amount_i);
  assign k   = (mag > aalu_pkg::shamt_t'(W)) ? aalu_pkg::shamt_t'(W) : mag;
  assign shl = {1'b0, acc_i} << k;
  assign shr = {acc_i, 1'b0} >> k;

  always_comb begin
    r    = acc_i;
    c    = 1'b0;
    o    = 1'b0;
    keep = 1'b0;
    case (aalu_pkg::op_e'(op_i))
      aalu_pkg::OP_PASS:   r = b;
      aalu_pkg::OP_NAND:   r = ~(acc_i & b);
      aalu_pkg::OP_SHR1:   r = acc_i >> 1;
      aalu_pkg::OP_ADD: begin
        r = sum[W-1:0];
        c = sum[W];
        o = add_ovf;
      end
      aalu_pkg::OP_NOT:    r = ~acc_i;
      aalu_pkg::OP_AND:    r = acc_i & b;
      aalu_pkg::OP_OR:     r = acc_i | b;
      aalu_pkg::OP_XOR:    r = acc_i ^ b;
      aalu_pkg::OP_LSHIFT: begin
        if (mag == '0) begin
          keep = 1'b1;
        end else if (shift_amount_i[aalu_pkg::ShiftBits-1]) begin
          r = shr[W:1];
          c = shr[0];
        end else begin
          r = shl[W-1:0];
          c = shl[W];
        end
      end
      aalu_pkg::OP_NEGATE: r = '0 - acc_i;
      aalu_pkg::OP_SUB:    r = acc_i - b;
      aalu_pkg::OP_MUL:    r = acc_i * b;
      default:             keep = 1'b1;
    endcase
  end

  always_comb begin
    if (keep) begin
      res_o.acc   = acc_i;
      res_o.flags = flags_i;
    end else begin
      res_o.acc     = r;
      res_o.flags.z = (r == '0);
      res_o.flags.c = c;
      res_o.flags.o = o;
      res_o.flags.n = r[W-1];
    end
  end

endmodule
